/* src/ems2d_pkg.sv */
// Shared constants, pipeline stage record and month table for the epoch-to-date core.
`default_nettype none

package ems2d_pkg;

  // Field widths.
  localparam int MS_W    = 48;
  localparam int EPOCH_W = 22;
  localparam int DAYS_W  = 22;
  localparam int TOD_W   = 27;
  localparam int JD_W    = 24;
  localparam int YEAR_W  = 14;

  // Time-of-day divisors.
  localparam logic [MS_W-1:0]  DAY_LENGTH_MS = 48'd86400000;
  localparam logic [TOD_W-1:0] MS_PER_HOUR   = 27'd3600000;
  localparam logic [TOD_W-1:0] MS_PER_MINUTE = 27'd60000;
  localparam logic [TOD_W-1:0] MS_PER_SECOND = 27'd1000;

  // Calendar cycle lengths in days.
  localparam logic [JD_W-1:0] JD_SHIFT       = 24'd32044;
  localparam logic [JD_W-1:0] DAYS_PER_400Y  = 24'd146097;
  localparam logic [JD_W-1:0] CENTURY_1      = 24'd36524;
  localparam logic [JD_W-1:0] CENTURY_2      = 24'd73048;
  localparam logic [JD_W-1:0] CENTURY_3      = 24'd109572;
  localparam logic [JD_W-1:0] DAYS_PER_4Y    = 24'd1461;
  localparam logic [JD_W-1:0] YEAR_1         = 24'd365;
  localparam logic [JD_W-1:0] YEAR_2         = 24'd730;
  localparam logic [JD_W-1:0] YEAR_3         = 24'd1095;
  localparam logic [JD_W-1:0] MONTH_SCALE    = 24'd5;
  localparam logic [JD_W-1:0] MONTH_BIAS     = 24'd308;
  localparam logic [JD_W-1:0] MONTH_DIVISOR  = 24'd153;
  localparam logic [14:0]     YEAR_BIAS      = 15'd4800;
  localparam logic [3:0]      MONTH_Q_BIAS   = 4'd2;
  // March-based month index of January.
  localparam logic [3:0]      JANUARY_INDEX  = 4'd10;

  localparam logic [EPOCH_W-1:0] EPOCH_RESET = 22'd2415020;

  // Pipeline schedule: first operation index of each division and the single steps.
  localparam int DAY_STEPS  = 22;
  localparam int HOUR_STEPS = 5;
  localparam int MIN_STEPS  = 6;
  localparam int SEC_STEPS  = 6;
  localparam int G_STEPS    = 6;
  localparam int B_STEPS    = 5;
  localparam int Q_STEPS    = 4;

  localparam int JD_OP      = DAY_STEPS;
  localparam int HOUR_FIRST = DAY_STEPS;
  localparam int MIN_FIRST  = HOUR_FIRST + HOUR_STEPS;
  localparam int SEC_FIRST  = MIN_FIRST + MIN_STEPS;
  localparam int SEC_END    = SEC_FIRST + SEC_STEPS;
  localparam int G_FIRST    = JD_OP + 1;
  localparam int C_OP       = G_FIRST + G_STEPS;
  localparam int B_FIRST    = C_OP + 1;
  localparam int A_OP       = B_FIRST + B_STEPS;
  localparam int Y_OP       = A_OP + 1;
  localparam int Q_FIRST    = Y_OP + 1;
  localparam int FINAL_OP   = Q_FIRST + Q_STEPS;
  localparam int NUM_STAGES = FINAL_OP + 1;

  typedef struct packed {
    logic [MS_W-1:0]   ms_rem;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod_rem;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [JD_W-1:0]   jd_rem;
    logic [5:0]        g;
    logic [1:0]        c;
    logic [4:0]        b;
    logic [1:0]        a;
    logic [8:0]        da;
    logic [14:0]       y;
    logic [3:0]        q;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
  } stage_t;

  // Days from the start of March to the start of March-based month m.
  function automatic logic [8:0] month_offset(logic [3:0] m);
    logic [8:0] ofs;
    case (m)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

/* src/epoch_milliseconds_to_date_core.sv */
// Top level: pipelined conversion of epoch milliseconds to calendar date and time of day.
// Throughput is one transaction per cycle unless a stalled output fills the pipeline;
// the 22-stage restoring division by the day length, followed by the calendar cycle
// divisions, sets the pipeline depth. A stalled output only holds the stages behind it up
// to the first empty stage.
// Synchronous reset clears all valid bits and loads epoch_julian_day with 2415020.
`default_nettype none

module epoch_milliseconds_to_date_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [21:0] cfg_wdata,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [47:0] elapsed_ms,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output logic [4:0]       day_of_month,
  output logic [3:0]       month_number,
  output logic [13:0]      year_number,
  output logic [4:0]       hour_of_day,
  output logic [5:0]       minute_of_hour,
  output logic [5:0]       second_of_minute,
  output logic [9:0]       millisecond_part
);

  localparam int N    = ems2d_pkg::NUM_STAGES;
  localparam int LAST = N - 1;

  logic [ems2d_pkg::EPOCH_W-1:0] epoch_julian_day;
  ems2d_pkg::stage_t stg      [N];
  ems2d_pkg::stage_t stg_next [N];
  logic [N-1:0] vld;
  logic [N-1:0] vld_in;
  logic [N-1:0] adv;

  assign vld_in = {vld[N-2:0], req_valid};

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int DAY_SH  = (k < ems2d_pkg::DAY_STEPS) ? ems2d_pkg::DAY_STEPS - 1 - k : 0;
    localparam int HOUR_SH = (k >= ems2d_pkg::HOUR_FIRST && k < ems2d_pkg::MIN_FIRST) ?
                             ems2d_pkg::MIN_FIRST - 1 - k : 0;
    localparam int MIN_SH  = (k >= ems2d_pkg::MIN_FIRST && k < ems2d_pkg::SEC_FIRST) ?
                             ems2d_pkg::SEC_FIRST - 1 - k : 0;
    localparam int SEC_SH  = (k >= ems2d_pkg::SEC_FIRST && k < ems2d_pkg::SEC_END) ?
                             ems2d_pkg::SEC_END - 1 - k : 0;
    localparam int G_SH    = (k >= ems2d_pkg::G_FIRST && k < ems2d_pkg::C_OP) ?
                             ems2d_pkg::C_OP - 1 - k : 0;
    localparam int B_SH    = (k >= ems2d_pkg::B_FIRST && k < ems2d_pkg::A_OP) ?
                             ems2d_pkg::A_OP - 1 - k : 0;
    localparam int Q_SH    = (k >= ems2d_pkg::Q_FIRST && k < ems2d_pkg::FINAL_OP) ?
                             ems2d_pkg::FINAL_OP - 1 - k : 0;

    localparam logic [ems2d_pkg::MS_W-1:0]  DAY_DIV  = ems2d_pkg::DAY_LENGTH_MS << DAY_SH;
    localparam logic [ems2d_pkg::TOD_W-1:0] HOUR_DIV = ems2d_pkg::MS_PER_HOUR << HOUR_SH;
    localparam logic [ems2d_pkg::TOD_W-1:0] MIN_DIV  = ems2d_pkg::MS_PER_MINUTE << MIN_SH;
    localparam logic [ems2d_pkg::TOD_W-1:0] SEC_DIV  = ems2d_pkg::MS_PER_SECOND << SEC_SH;
    localparam logic [ems2d_pkg::JD_W-1:0]  G_DIV    = ems2d_pkg::DAYS_PER_400Y << G_SH;
    localparam logic [ems2d_pkg::JD_W-1:0]  B_DIV    = ems2d_pkg::DAYS_PER_4Y << B_SH;
    localparam logic [ems2d_pkg::JD_W-1:0]  Q_DIV    = ems2d_pkg::MONTH_DIVISOR << Q_SH;

    ems2d_pkg::stage_t base;

    if (k == 0) begin : g_first
      always_comb begin
        base = '0;
        base.ms_rem = elapsed_ms;
      end
    end else begin : g_rest
      assign base = stg[k-1];
    end

    always_comb begin
      ems2d_pkg::stage_t s;
      logic [3:0]  m;
      logic        late_month;
      logic [14:0] yr;
      s = base;
      m = '0;
      late_month = 1'b0;
      yr = '0;

      // Restoring division of the millisecond count by the day length.
      if (k < ems2d_pkg::DAY_STEPS) begin
        if (s.ms_rem >= DAY_DIV) begin
          s.ms_rem = s.ms_rem - DAY_DIV;
          s.days[DAY_SH] = 1'b1;
        end
        if (k == ems2d_pkg::DAY_STEPS - 1) begin
          s.tod_rem = s.ms_rem[ems2d_pkg::TOD_W-1:0];
        end
      end

      if (k == ems2d_pkg::JD_OP) begin
        s.jd_rem = ems2d_pkg::JD_W'(s.days) + ems2d_pkg::JD_W'(epoch_julian_day)
                   + ems2d_pkg::JD_SHIFT;
        s.ms_rem = '0;
        s.days   = '0;
      end

      // Time of day: hours, minutes and seconds, one quotient bit per stage.
      if (k >= ems2d_pkg::HOUR_FIRST && k < ems2d_pkg::MIN_FIRST) begin
        if (s.tod_rem >= HOUR_DIV) begin
          s.tod_rem = s.tod_rem - HOUR_DIV;
          s.hour[HOUR_SH] = 1'b1;
        end
      end
      if (k >= ems2d_pkg::MIN_FIRST && k < ems2d_pkg::SEC_FIRST) begin
        if (s.tod_rem >= MIN_DIV) begin
          s.tod_rem = s.tod_rem - MIN_DIV;
          s.minute[MIN_SH] = 1'b1;
        end
      end
      if (k >= ems2d_pkg::SEC_FIRST && k < ems2d_pkg::SEC_END) begin
        if (s.tod_rem >= SEC_DIV) begin
          s.tod_rem = s.tod_rem - SEC_DIV;
          s.second[SEC_SH] = 1'b1;
        end
      end

      // 400-year cycles.
      if (k >= ems2d_pkg::G_FIRST && k < ems2d_pkg::C_OP) begin
        if (s.jd_rem >= G_DIV) begin
          s.jd_rem = s.jd_rem - G_DIV;
          s.g[G_SH] = 1'b1;
        end
      end

      // Centuries within the cycle; the last century of a cycle keeps its extra day.
      if (k == ems2d_pkg::C_OP) begin
        if (s.jd_rem >= ems2d_pkg::CENTURY_3) begin
          s.c = 2'd3;
          s.jd_rem = s.jd_rem - ems2d_pkg::CENTURY_3;
        end else if (s.jd_rem >= ems2d_pkg::CENTURY_2) begin
          s.c = 2'd2;
          s.jd_rem = s.jd_rem - ems2d_pkg::CENTURY_2;
        end else if (s.jd_rem >= ems2d_pkg::CENTURY_1) begin
          s.c = 2'd1;
          s.jd_rem = s.jd_rem - ems2d_pkg::CENTURY_1;
        end else begin
          s.c = 2'd0;
        end
      end

      // Four-year cycles.
      if (k >= ems2d_pkg::B_FIRST && k < ems2d_pkg::A_OP) begin
        if (s.jd_rem >= B_DIV) begin
          s.jd_rem = s.jd_rem - B_DIV;
          s.b[B_SH] = 1'b1;
        end
      end

      // Years within the four-year cycle; the leap day stays in the last year.
      if (k == ems2d_pkg::A_OP) begin
        if (s.jd_rem >= ems2d_pkg::YEAR_3) begin
          s.a = 2'd3;
          s.jd_rem = s.jd_rem - ems2d_pkg::YEAR_3;
        end else if (s.jd_rem >= ems2d_pkg::YEAR_2) begin
          s.a = 2'd2;
          s.jd_rem = s.jd_rem - ems2d_pkg::YEAR_2;
        end else if (s.jd_rem >= ems2d_pkg::YEAR_1) begin
          s.a = 2'd1;
          s.jd_rem = s.jd_rem - ems2d_pkg::YEAR_1;
        end else begin
          s.a = 2'd0;
        end
        s.da = s.jd_rem[8:0];
      end

      if (k == ems2d_pkg::Y_OP) begin
        s.y = 15'(s.g) * 15'd400 + 15'(s.c) * 15'd100 + 15'(s.b) * 15'd4 + 15'(s.a);
        s.jd_rem = ems2d_pkg::JD_W'(s.da) * ems2d_pkg::MONTH_SCALE + ems2d_pkg::MONTH_BIAS;
      end

      // Month quotient of the scaled day of the March-based year.
      if (k >= ems2d_pkg::Q_FIRST && k < ems2d_pkg::FINAL_OP) begin
        if (s.jd_rem >= Q_DIV) begin
          s.jd_rem = s.jd_rem - Q_DIV;
          s.q[Q_SH] = 1'b1;
        end
      end

      if (k == ems2d_pkg::FINAL_OP) begin
        m = s.q - ems2d_pkg::MONTH_Q_BIAS;
        late_month = (m >= ems2d_pkg::JANUARY_INDEX);
        s.day = 5'(s.da - ems2d_pkg::month_offset(m) + 9'd1);
        s.month = late_month ? m - 4'd9 : m + 4'd3;
        yr = s.y + {14'd0, late_month} - ems2d_pkg::YEAR_BIAS;
        s.year = yr[ems2d_pkg::YEAR_W-1:0];
      end

      stg_next[k] = s;
    end

    // A stage moves when it is empty or some stage downstream of it can move.
    assign adv[k] = rsp_ready || !(&vld[LAST:k]);

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld              <= '0;
      epoch_julian_day <= ems2d_pkg::EPOCH_RESET;
    end else begin
      if (cfg_we) begin
        epoch_julian_day <= cfg_wdata;
      end
      for (int i = 0; i < N; i++) begin
        if (adv[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  assign req_ready        = adv[0];
  assign rsp_valid        = vld[LAST];
  assign day_of_month     = stg[LAST].day;
  assign month_number     = stg[LAST].month;
  assign year_number      = stg[LAST].year;
  assign hour_of_day      = stg[LAST].hour;
  assign minute_of_hour   = stg[LAST].minute;
  assign second_of_minute = stg[LAST].second;
  assign millisecond_part = stg[LAST].tod_rem[9:0];

endmodule

`default_nettype wire

/* src/ems2d_checker.sv */
// Port-level checker for the epoch-to-date core and its bind to the top level.
`default_nettype none

module ems2d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [4:0]  day_of_month,
  input wire logic [3:0]  month_number,
  input wire logic [13:0] year_number,
  input wire logic [4:0]  hour_of_day,
  input wire logic [5:0]  minute_of_hour,
  input wire logic [5:0]  second_of_minute,
  input wire logic [9:0]  millisecond_part
);

  // A pending result's year, month, day and millisecond must not change until its transaction completes.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(year_number) &&
      $stable(month_number) && $stable(day_of_month) && $stable(millisecond_part))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // Input back-pressure only comes from a full pipeline behind a stalled output.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("input stalled without a stalled output");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> month_number >= 4'd1 && month_number <= 4'd12 &&
      day_of_month >= 5'd1)
    else $error("calendar field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 &&
      second_of_minute <= 6'd59 && millisecond_part <= 10'd999)
    else $error("time-of-day field out of range");

endmodule

bind epoch_milliseconds_to_date_core ems2d_checker u_ems2d_checker (.*);

`default_nettype wire

/* tb/sv/date_conversion_checker.sv */
// Checker for the epoch-to-date core: predicts each conversion and compares the results.
module date_conversion_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [21:0] cfg_wdata,
  input  wire logic        req_valid,
  input  wire logic        req_ready,
  input  wire logic [47:0] elapsed_ms,
  input  wire logic        rsp_valid,
  input  wire logic        rsp_ready,
  input  wire logic [4:0]  day_of_month,
  input  wire logic [3:0]  month_number,
  input  wire logic [13:0] year_number,
  input  wire logic [4:0]  hour_of_day,
  input  wire logic [5:0]  minute_of_hour,
  input  wire logic [5:0]  second_of_minute,
  input  wire logic [9:0]  millisecond_part,
  output int               mismatch_count,
  output int               pending_count,
  output int               results_checked
);

  typedef struct packed {
    logic [ems2d_pkg::MS_W-1:0]   ms;
    logic [4:0]                   day;
    logic [3:0]                   month;
    logic [ems2d_pkg::YEAR_W-1:0] year;
    logic [4:0]                   hour;
    logic [5:0]                   minute;
    logic [5:0]                   second;
    logic [9:0]                   msec;
  } calendar_t;

  calendar_t                       expected_dates[$];
  logic [ems2d_pkg::EPOCH_W-1:0]   epoch_jd;

  initial begin
    mismatch_count  = 0;
    pending_count   = 0;
    results_checked = 0;
    epoch_jd        = ems2d_pkg::EPOCH_RESET;
  end

  // Julian day number to Gregorian date, done through the 400/100/4/1-year cycles
  // with months counted from March.
  function automatic calendar_t to_calendar(logic [ems2d_pkg::MS_W-1:0] ms,
                                            logic [ems2d_pkg::EPOCH_W-1:0] jd0);
    longint unsigned total, days, tod;
    longint shifted, era, era_day, cent, cent_day, quad, quad_day, yr, yr_day;
    longint full_year, mar_month, mday;
    calendar_t r;
    total     = 64'(ms);
    days      = total / 64'd86400000;
    tod       = total % 64'd86400000;
    shifted   = longint'(days) + longint'(jd0) + 32044;
    era       = shifted / 146097;
    era_day   = shifted % 146097;
    cent      = ((era_day / 36524 + 1) * 3) / 4;
    cent_day  = era_day - cent * 36524;
    quad      = cent_day / 1461;
    quad_day  = cent_day % 1461;
    yr        = ((quad_day / 365 + 1) * 3) / 4;
    yr_day    = quad_day - yr * 365;
    full_year = era * 400 + cent * 100 + quad * 4 + yr;
    mar_month = (yr_day * 5 + 308) / 153 - 2;
    mday      = yr_day - (mar_month + 4) * 153 / 5 + 122;
    r.ms      = ms;
    // Years before zero wrap into the 14-bit field as two's complement.
    r.year    = 14'(full_year - 4800 + (mar_month + 2) / 12);
    r.month   = 4'((mar_month + 2) % 12 + 1);
    r.day     = 5'(mday + 1);
    r.hour    = 5'(tod / 64'd3600000);
    r.minute  = 6'((tod % 64'd3600000) / 64'd60000);
    r.second  = 6'((tod % 64'd60000) / 64'd1000);
    r.msec    = 10'(tod % 64'd1000);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input logic [ems2d_pkg::MS_W-1:0] ms);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d (elapsed_ms %0d, epoch %0d)",
                                name, got, want, ms, epoch_jd));
  endtask

  always @(posedge clk) begin : monitor
    calendar_t want;
    if (rst) begin
      expected_dates.delete();
      epoch_jd = ems2d_pkg::EPOCH_RESET;
    end else begin
      if (rsp_valid && rsp_ready) begin
        results_checked++;
        if (expected_dates.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_dates.pop_front();
          check_field("day_of_month", int'(day_of_month), int'(want.day), want.ms);
          check_field("month_number", int'(month_number), int'(want.month), want.ms);
          check_field("year_number", int'(year_number), int'(want.year), want.ms);
          check_field("hour_of_day", int'(hour_of_day), int'(want.hour), want.ms);
          check_field("minute_of_hour", int'(minute_of_hour), int'(want.minute), want.ms);
          check_field("second_of_minute", int'(second_of_minute), int'(want.second),
                      want.ms);
          check_field("millisecond_part", int'(millisecond_part), int'(want.msec),
                      want.ms);
        end
      end
      if (req_valid && req_ready)
        expected_dates.push_back(to_calendar(elapsed_ms, epoch_jd));
      if (cfg_we)
        epoch_jd = cfg_wdata;
    end
    pending_count = expected_dates.size();
  end

endmodule

/* tb/sv/epoch_milliseconds_to_date_core_tb.sv */
// Testbench top for the epoch-to-date core: clock, reset, stimulus and verdict.
module epoch_milliseconds_to_date_core_tb;

  localparam int     RANDOM_PER_PHASE = 225;
  localparam int     NUM_PHASES       = 6;
  localparam int     WATCHDOG_LIMIT   = 3000;
  localparam int     LONG_HOLD        = 400;
  localparam int     DRAIN_CYCLES     = 60;
  localparam longint DAY_MS           = 86400000;
  // Last whole day that still fits in a 48-bit millisecond count.
  localparam longint LAST_DAY         = 3257811;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic [21:0] cfg_wdata  = '0;
  logic        req_valid  = 1'b0;
  logic [47:0] elapsed_ms = '0;
  logic        rsp_ready  = 1'b0;
  logic        req_ready;
  logic        rsp_valid;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [13:0] year_number;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;
  logic [9:0]  millisecond_part;

  int mismatches;
  int pending;
  int checked;
  int sent           = 0;
  int epochs_loaded  = 0;
  int idle_cycles    = 0;
  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b1;
  bit long_hold_pending = 1'b0;

  epoch_milliseconds_to_date_core u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .elapsed_ms       (elapsed_ms),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .day_of_month     (day_of_month),
    .month_number     (month_number),
    .year_number      (year_number),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .millisecond_part (millisecond_part)
  );

  date_conversion_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .elapsed_ms       (elapsed_ms),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .day_of_month     (day_of_month),
    .month_number     (month_number),
    .year_number      (year_number),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .millisecond_part (millisecond_part),
    .mismatch_count   (mismatches),
    .pending_count    (pending),
    .results_checked  (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, giving up", $time, idle_cycles);
      $display("[epoch_milliseconds_to_date_core] ERROR");
      $finish;
    end
  end

  // Result side: random stalls when receiver_idles is set, one long hold-off on request.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      @(negedge clk);
      stall = receiver_idles ? $urandom_range(0, 10) : 0;
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_timestamp(input logic [47:0] value);
    int gap;
    gap = sender_idles ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    elapsed_ms <= value;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_day(input longint day_num, input longint tod);
    send_timestamp(48'(day_num * DAY_MS + tod));
  endtask

  // Register writes happen only with the pipeline drained.
  task automatic load_epoch(input logic [21:0] jd);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= jd;
    @(negedge clk);
    cfg_we    <= 1'b0;
    epochs_loaded++;
  endtask

  function automatic logic [47:0] random_timestamp();
    longint     day_num;
    longint     tod;
    logic [47:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        v[47:32] = 16'($urandom_range(0, 65535));
        v[31:0]  = $urandom;
      end
      3, 4, 5: begin
        day_num = longint'($urandom_range(0, 150000));
        tod     = longint'($urandom_range(0, 86399999));
        v       = 48'(day_num * DAY_MS + tod);
      end
      6, 7: begin
        // First or last millisecond of a day.
        day_num = longint'($urandom_range(0, 32'(LAST_DAY)));
        tod     = $urandom_range(0, 1) ? longint'(86399999) : longint'(0);
        v       = 48'(day_num * DAY_MS + tod);
      end
      8: v = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 500000000));
      default: begin
        day_num = longint'($urandom_range(0, 32'(LAST_DAY)));
        tod     = longint'($urandom_range(0, 86399999));
        v       = 48'(day_num * DAY_MS + tod);
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [21:0] phase_epoch[NUM_PHASES];
    phase_epoch[0] = 22'd2440588;
    phase_epoch[1] = 22'd4194303;
    phase_epoch[2] = 22'd0;
    phase_epoch[3] = 22'($urandom_range(0, 4194303));
    phase_epoch[4] = 22'd2299161;
    phase_epoch[5] = 22'($urandom_range(0, 1000000));

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset epoch: time-of-day edges, century and leap days.
    send_timestamp(48'd0);
    send_timestamp(48'd999);
    send_timestamp(48'd1000);
    send_timestamp(48'd59999);
    send_timestamp(48'd60000);
    send_timestamp(48'd3599999);
    send_timestamp(48'd3600000);
    send_timestamp(48'd86399999);
    send_timestamp(48'd86400000);
    send_day(58, 0);
    send_day(59, 0);
    send_day(1519, 43200000);
    send_day(36523, 86399999);
    send_day(36524, 0);
    send_day(36583, 12345678);
    send_day(36584, 0);
    send_day(LAST_DAY, 86399999);
    send_timestamp(48'hFFFF_FFFF_FFFF);

    // Register extremes: the smallest epoch gives years far before zero.
    load_epoch(22'd0);
    send_timestamp(48'd0);
    send_timestamp(48'hFFFF_FFFF_FFFF);
    load_epoch(22'h3FFFFF);
    send_timestamp(48'd0);
    send_timestamp(48'hFFFF_FFFF_FFFF);

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_epoch(phase_epoch[p]);
      sender_idles   = p[0];
      receiver_idles = p[1];
      if (p == 1 || p == 4)
        long_hold_pending = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        send_timestamp(random_timestamp());
    end

    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Converted %0d timestamps under %0d epoch settings; %0d results compared.",
             sent, epochs_loaded + 1, checked);
    $display("Included day and leap-day edges, years before zero, field maxima and long stalls.");
    if (mismatches == 0)
      $display("[epoch_milliseconds_to_date_core] OK");
    else
      $display("[epoch_milliseconds_to_date_core] ERROR");
    $finish;
  end

endmodule
